### design/lkvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared constants, types and codes of the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 6;
    localparam int CMP_W   = CNT_W + CFG_W;

    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(32);

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_FILL   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } lkvc_state_t;

    // One registered read of the key/value store
    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
        logic             key_eq;
        logic [VAL_W-1:0] value;
    } lkvc_rd_t;

endpackage
`default_nettype wire

### design/lru_key_value_cache_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Content
//  s_        in         s_tvalid/s_tready  tdata: key, fill value; tuser: command
//  m_        out        m_tvalid/m_tready  tdata: found value; tuser: hit, evicted
//  cfg_      in         cfg_wr_en          capacity in use (6 bits)
//
//  Items are taken one at a time; the next is accepted only after the update:
//  the keys are scanned one per cycle through the single read port of the
//  key/value memory, then the recency ranks update in the update state.
//  Reset clears valid bits and ranks at once; no clearing pass is run.
//  A result that is not taken holds the block before its update cycle.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top
    import lkvc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [95:0]      s_tdata,   // [63:0] entity_key, [95:64] fill_value
    input  wire logic [0:0]       s_tuser,   // [0] command
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [31:0]           m_tdata,   // [31:0] found_value
    output logic [1:0]            m_tuser,   // [0] hit, [1] evicted
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data
);

    lkvc_state_t state_reg, state_next;

    logic [CFG_W-1:0] cap_reg;
    logic [CNT_W-1:0] entries_used_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0] rank_reg [ENTRIES];

    logic             cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic             match_found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic [IDX_W-1:0] match_rank_reg;
    logic [VAL_W-1:0] match_value_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             lru_found_reg;
    logic [IDX_W-1:0] lru_idx_reg;
    logic [IDX_W-1:0] lru_rank_reg;

    logic             m_tvalid_reg;
    logic [31:0]      m_tdata_reg;
    logic [1:0]       m_tuser_reg;

    logic             accept;
    logic             rd_en;
    logic             upd_go;
    logic             out_room;
    lkvc_rd_t         rd;

    logic             scan_v;
    logic [IDX_W-1:0] scan_rank;
    logic             scan_last;

    logic [CMP_W-1:0] cap_eff;
    logic             has_room;
    logic             do_mmr;
    logic             do_write;
    logic             do_new;
    logic [IDX_W-1:0] tgt;
    logic [IDX_W-1:0] tgt_rank;
    logic             res_hit;
    logic             res_evicted;
    logic [VAL_W-1:0] res_value;

    lkvc_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (rd_en),
        .rd_addr    (cnt_reg[IDX_W-1:0]),
        .search_key (key_reg),
        .wr_en      (do_write),
        .wr_addr    (tgt),
        .wr_key     (key_reg),
        .wr_value   (value_reg),
        .rd_o       (rd)
    );

    assign out_room  = !m_tvalid_reg || m_tready;
    assign scan_v    = valid_reg[rd.idx];
    assign scan_rank = rank_reg[rd.idx];
    assign scan_last = rd.vld && (rd.idx == IDX_W'(ENTRIES - 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_room) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        upd_go   = 1'b0;
        case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_SCAN:   rd_en    = (cnt_reg < CNT_W'(ENTRIES));
            ST_UPDATE: upd_go   = out_room;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // Capacity clamped to the range 1..ENTRIES
    always_comb begin
        cap_eff = CMP_W'(cap_reg);
        if (cap_reg == '0) begin
            cap_eff = CMP_W'(1);
        end else if (CMP_W'(cap_reg) > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end
    end

    assign has_room = CMP_W'(entries_used_reg) < cap_eff;

    // Choose the target entry of the update
    always_comb begin
        do_mmr      = 1'b0;
        do_new      = 1'b0;
        tgt         = match_idx_reg;
        tgt_rank    = match_rank_reg;
        res_hit     = 1'b0;
        res_evicted = 1'b0;
        res_value   = '0;
        if (cmd_reg == CMD_LOOKUP) begin
            if (match_found_reg) begin
                do_mmr    = 1'b1;
                res_hit   = 1'b1;
                res_value = match_value_reg;
            end
        end else if (match_found_reg) begin
            do_mmr = 1'b1;
        end else if (has_room) begin
            do_mmr   = 1'b1;
            do_new   = 1'b1;
            tgt      = free_idx_reg;
            tgt_rank = entries_used_reg[IDX_W-1:0];
        end else begin
            do_mmr      = 1'b1;
            res_evicted = 1'b1;
            tgt         = lru_idx_reg;
            tgt_rank    = lru_rank_reg;
        end
    end

    assign do_write = upd_go && (cmd_reg == CMD_FILL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            cap_reg          <= CAP_RESET;
            entries_used_reg <= '0;
            valid_reg        <= '0;
            m_tvalid_reg     <= 1'b0;
            for (int j = 0; j < ENTRIES; j++) begin
                rank_reg[j] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (upd_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (upd_go && do_mmr) begin
                // age every valid entry younger than the target
                for (int j = 0; j < ENTRIES; j++) begin
                    if (valid_reg[j] && (IDX_W'(j) != tgt) && (rank_reg[j] < tgt_rank)) begin
                        rank_reg[j] <= rank_reg[j] + IDX_W'(1);
                    end
                end
                rank_reg[tgt] <= '0;
                if (do_new) begin
                    valid_reg[tgt]   <= 1'b1;
                    entries_used_reg <= entries_used_reg + CNT_W'(1);
                end
            end
        end
    end

    // Item capture and scan tracking
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg         <= s_tuser[0];
            key_reg         <= s_tdata[KEY_W-1:0];
            value_reg       <= s_tdata[KEY_W+VAL_W-1:KEY_W];
            cnt_reg         <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            lru_found_reg   <= 1'b0;
        end else begin
            if (rd_en) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (rd.vld) begin
                if (scan_v && rd.key_eq && !match_found_reg) begin
                    match_found_reg <= 1'b1;
                    match_idx_reg   <= rd.idx;
                    match_rank_reg  <= scan_rank;
                    match_value_reg <= rd.value;
                end
                if (!scan_v && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= rd.idx;
                end
                if (scan_v && (!lru_found_reg || (scan_rank > lru_rank_reg))) begin
                    lru_found_reg <= 1'b1;
                    lru_idx_reg   <= rd.idx;
                    lru_rank_reg  <= scan_rank;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_go) begin
            m_tdata_reg <= res_value;
            m_tuser_reg <= {res_evicted, res_hit};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entries_used_reg <= CNT_W'(ENTRIES))
        else $error("entries in use exceed the store size");

    a_used_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == int'(entries_used_reg))
        else $error("valid bits disagree with the use count");

    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_SCAN))
        else $error("accepted word did not start a scan");

    a_hit_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tuser_reg[0] && m_tuser_reg[1]))
        else $error("result flags both hit and eviction");

    a_write_update: assert property (@(posedge aclk) disable iff (!aresetn)
        do_write |-> (state_reg == ST_UPDATE) && !rd_en)
        else $error("memory write outside the update cycle");

endmodule
`default_nettype wire

### design/lkvc_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_store
// Key/value memory with one write port and one registered read port; the
// read key is compared against the key under search.
// ----------------------------------------------------------------------------
module lkvc_store
    import lkvc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    input  wire logic [KEY_W-1:0] search_key,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [KEY_W-1:0] wr_key,
    input  wire logic [VAL_W-1:0] wr_value,
    output lkvc_rd_t              rd_o
);

    logic [KEY_W+VAL_W-1:0] mem [ENTRIES];

    logic [KEY_W+VAL_W-1:0] rd_data_reg;
    logic                   rd_vld_reg;
    logic [IDX_W-1:0]       rd_idx_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_key, wr_value};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= rd_en;
        end
    end

    assign rd_o.vld    = rd_vld_reg;
    assign rd_o.idx    = rd_idx_reg;
    assign rd_o.key_eq = (rd_data_reg[KEY_W+VAL_W-1:VAL_W] == search_key);
    assign rd_o.value  = rd_data_reg[VAL_W-1:0];

endmodule
`default_nettype wire

### dv/lkvc_sb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_sb_pkg
// Scoreboard for the LRU key/value cache: keeps its own copy of the cache
// contents and recency order, works out the answer to every accepted word and
// checks the answers that come back, in order.
// ----------------------------------------------------------------------------
package lkvc_sb_pkg;
    import lkvc_pkg::*;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] value;
        logic             evicted;
    } cache_answer_t;

    class lkvc_cache_scoreboard;
        logic [KEY_W-1:0] stored_keys   [ENTRIES];
        logic [VAL_W-1:0] stored_values [ENTRIES];
        bit               slot_valid    [ENTRIES];
        int unsigned      slot_rank     [ENTRIES];
        int unsigned      entries_used;
        logic [CFG_W-1:0] capacity;
        cache_answer_t    awaited_answers [$];
        int unsigned      mismatches;

        function void clear();
            for (int i = 0; i < ENTRIES; i++) begin
                stored_keys[i]   = '0;
                stored_values[i] = '0;
                slot_valid[i]    = 1'b0;
                slot_rank[i]     = 0;
            end
            entries_used = 0;
            capacity     = CAP_RESET;
            mismatches   = 0;
            awaited_answers.delete();
        endfunction

        function void set_capacity(logic [CFG_W-1:0] c);
            capacity = c;
        endfunction

        // Clamp the register to 1..ENTRIES
        function int unsigned usable_slots();
            int unsigned c;
            c = capacity;
            if (c < 1)
                c = 1;
            if (c > ENTRIES)
                c = ENTRIES;
            return c;
        endfunction

        function int slot_of(logic [KEY_W-1:0] key);
            for (int i = 0; i < ENTRIES; i++)
                if (slot_valid[i] && stored_keys[i] == key)
                    return i;
            return -1;
        endfunction

        // Age every valid entry younger than idx by one, then put idx on top
        function void make_newest(int idx);
            int unsigned r;
            r = slot_rank[idx];
            for (int j = 0; j < ENTRIES; j++)
                if (j != idx && slot_valid[j] && slot_rank[j] < r)
                    slot_rank[j]++;
            slot_rank[idx] = 0;
        endfunction

        function int oldest_slot();
            int best;
            best = -1;
            for (int j = 0; j < ENTRIES; j++)
                if (slot_valid[j] && (best < 0 || slot_rank[j] > slot_rank[best]))
                    best = j;
            return best;
        endfunction

        function int first_free_slot();
            for (int j = 0; j < ENTRIES; j++)
                if (!slot_valid[j])
                    return j;
            return -1;
        endfunction

        function void note_request(logic cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
            cache_answer_t ans;
            int            idx;
            ans = '0;
            idx = slot_of(key);
            if (cmd == CMD_LOOKUP) begin
                if (idx >= 0) begin
                    ans.hit   = 1'b1;
                    ans.value = stored_values[idx];
                    make_newest(idx);
                end
            end else if (idx >= 0) begin
                // key already held: refresh the value, no eviction
                stored_values[idx] = val;
                make_newest(idx);
            end else begin
                if (entries_used < usable_slots()) begin
                    idx = first_free_slot();
                end else begin
                    idx = oldest_slot();
                    ans.evicted = (idx >= 0);
                end
                if (idx >= 0) begin
                    if (!ans.evicted) begin
                        slot_valid[idx] = 1'b1;
                        slot_rank[idx]  = entries_used;
                        entries_used++;
                    end
                    stored_keys[idx]   = key;
                    stored_values[idx] = val;
                    make_newest(idx);
                end
            end
            awaited_answers.push_back(ans);
        endfunction

        function void report(string what, cache_answer_t e, cache_answer_t g);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s: expected hit=%0b value=%h evicted=%0b, got hit=%0b value=%h evicted=%0b",
                         $time, what, e.hit, e.value, e.evicted, g.hit, g.value, g.evicted);
        endfunction

        function void check_response(logic [VAL_W-1:0] value, logic [1:0] user);
            cache_answer_t exp_ans;
            cache_answer_t got;
            got.hit     = user[0];
            got.value   = value;
            got.evicted = user[1];
            if (awaited_answers.size() == 0) begin
                report("unexpected word", '0, got);
                return;
            end
            exp_ans = awaited_answers.pop_front();
            if (got.hit !== exp_ans.hit || got.value !== exp_ans.value
                    || got.evicted !== exp_ans.evicted)
                report("wrong word", exp_ans, got);
        endfunction
    endclass

endpackage

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stand-alone bench for the LRU key/value cache: directed lookups and fills,
// then random phases at several capacities with idle bursts on both sides, a
// long output stall and a full drain, all checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
    import lkvc_pkg::*;
    import lkvc_sb_pkg::*;

    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = ENTRIES + 8;
    localparam int CHOKE_CYCLES  = 300;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    logic [95:0]      s_tdata     = '0;   // [63:0] entity_key, [95:64] fill_value
    logic [0:0]       s_tuser     = '0;   // [0] command
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    logic [31:0]      m_tdata;            // [31:0] found_value
    logic [1:0]       m_tuser;            // [0] hit, [1] evicted
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    lkvc_cache_scoreboard cache_sb;

    int unsigned items_sent    = 0;
    bit          calm          = 1'b0;
    bit          choke_wanted  = 1'b0;
    bit          choke_started = 1'b0;
    int          choke_left    = 0;
    int          stall_left    = 0;
    int          quiet_cycles  = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    lru_key_value_cache_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Result side: long hold-off on request, otherwise short random stalls
    always @(negedge aclk) begin
        if (choke_wanted && !choke_started) begin
            choke_started = 1'b1;
            choke_left    = CHOKE_CYCLES;
        end
        if (choke_left > 0) begin
            choke_left--;
            m_tready = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready = 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_tready   = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            cache_sb.check_response(m_tdata, m_tuser);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one word, maybe after an idle burst; return at the next falling edge
    task automatic offer(logic cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {val, key};
        do @(posedge aclk); while (!s_tready);
        cache_sb.note_request(cmd, key, val);
        items_sent++;
        @(negedge aclk);
    endtask

    // Drain every awaited answer, then let the final rank update finish
    task automatic settle();
        s_tvalid = 1'b0;
        while (cache_sb.awaited_answers.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] c);
        settle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = c;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        cache_sb.set_capacity(c);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    // Mostly lookup-then-fill-on-miss over a key pool a little larger than
    // what the cache holds; the rest refreshes and stray keys
    task automatic run_phase(int unsigned quota, bit squeeze, bit pause);
        logic [KEY_W-1:0] pool [$];
        logic [KEY_W-1:0] key;
        int unsigned      span;
        int unsigned      pool_target;
        int unsigned      stop_at;
        int unsigned      mid;
        int unsigned      roll;
        bit               paused;
        span = cache_sb.entries_used;
        if (cache_sb.usable_slots() > span)
            span = cache_sb.usable_slots();
        for (int i = 0; i < ENTRIES; i++)
            if (cache_sb.slot_valid[i])
                pool.push_back(cache_sb.stored_keys[i]);
        pool_target = span + $urandom_range(2, 8);
        while (pool.size() < pool_target)
            pool.push_back({$urandom(), $urandom()});
        stop_at = items_sent + quota;
        mid     = items_sent + quota / 2;
        paused  = 1'b0;
        while (items_sent < stop_at) begin
            if (squeeze && items_sent >= mid)
                choke_wanted = 1'b1;
            if (pause && !paused && items_sent >= mid) begin
                paused   = 1'b1;
                s_tvalid = 1'b0;
                while (cache_sb.awaited_answers.size() != 0)
                    @(negedge aclk);
            end
            key  = pool[$urandom_range(0, pool.size() - 1)];
            roll = $urandom_range(0, 19);
            if (roll < 15) begin
                offer(CMD_LOOKUP, key, pick_value());
                if (cache_sb.slot_of(key) < 0 && $urandom_range(0, 9) < 8)
                    offer(CMD_FILL, key, pick_value());
            end else if (roll < 18) begin
                offer(CMD_FILL, key, pick_value());
            end else if (roll == 18) begin
                offer(CMD_LOOKUP, {$urandom(), $urandom()}, pick_value());
            end else begin
                offer(CMD_FILL, {$urandom(), $urandom()}, pick_value());
            end
        end
    endtask

    initial begin
        cache_sb = new();
        cache_sb.clear();
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty cache, extreme keys and values, refill of a held key
        offer(CMD_LOOKUP, '0, '1);
        offer(CMD_FILL, '0, '0);
        offer(CMD_FILL, '1, '1);
        offer(CMD_LOOKUP, '0, '0);
        offer(CMD_LOOKUP, '1, '0);
        offer(CMD_FILL, '0, 32'hA5A5_5A5A);
        offer(CMD_LOOKUP, '0, '0);
        offer(CMD_LOOKUP, 64'h8000_0000_0000_0001, '0);
        offer(CMD_FILL, {32{2'b10}}, 32'h5555_5555);
        offer(CMD_FILL, {32{2'b01}}, 32'hAAAA_AAAA);
        offer(CMD_LOOKUP, {32{2'b10}}, '1);

        // Lower capacity under the four in use: new keys must evict
        write_capacity(6'd2);
        offer(CMD_FILL, 64'h0123_4567_89AB_CDEF, 32'h0000_0001);
        offer(CMD_LOOKUP, '1, '0);
        offer(CMD_FILL, 64'hFEDC_BA98_7654_3210, 32'h8000_0000);
        offer(CMD_FILL, 64'h0123_4567_89AB_CDEF, 32'h0000_0002);
        offer(CMD_LOOKUP, 64'h0123_4567_89AB_CDEF, '0);

        // Zero acts as one
        write_capacity(6'd0);
        offer(CMD_FILL, 64'h0000_0000_FFFF_FFFF, 32'hDEAD_BEEF);
        offer(CMD_LOOKUP, 64'h0000_0000_FFFF_FFFF, '0);

        // Above the store size acts as the store size
        write_capacity(6'd63);
        offer(CMD_FILL, 64'hFFFF_FFFF_0000_0000, 32'h1234_5678);
        offer(CMD_LOOKUP, 64'hFFFF_FFFF_0000_0000, '0);

        write_capacity(6'd1);
        run_phase(110, 1'b1, 1'b0);
        write_capacity(6'd12);
        run_phase(110, 1'b0, 1'b1);
        write_capacity(6'd33);
        run_phase(130, 1'b0, 1'b0);
        write_capacity(6'd0);
        run_phase(100, 1'b0, 1'b0);
        write_capacity(6'($urandom_range(2, 31)));
        run_phase(110, 1'b0, 1'b0);
        write_capacity(6'd63);
        run_phase(120, 1'b0, 1'b0);
        write_capacity(6'd32);
        calm = 1'b1;
        run_phase(300, 1'b0, 1'b0);

        settle();
        if (cache_sb.mismatches == 0 && cache_sb.awaited_answers.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### lru_key_value_cache_top.f
design/lkvc_pkg.sv
design/lkvc_store.sv
design/lru_key_value_cache_top.sv
dv/lkvc_sb_pkg.sv
dv/tb_top.sv
